[design/assert_macros.svh]
// Assertion helpers used by the validator core.
// Both macros assume a clock named clk_i and an active-low reset named rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RFV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define RFV_ASSERT_NEVER(lbl, cond) \
  `RFV_ASSERT(lbl, !(cond))
`else
`define RFV_ASSERT(lbl, prop)
`define RFV_ASSERT_NEVER(lbl, cond)
`endif
`endif

[design/rfv_pkg.sv]
package rfv_pkg;

  localparam int unsigned CORR_ID_BYTES = 4;
  localparam int unsigned OFFSET_BITS   = 16;

  localparam int unsigned HDR_BYTES    = 1 + CORR_ID_BYTES + 4;
  localparam int unsigned HP_W         = $clog2(HDR_BYTES + 1);
  localparam int unsigned LEN_START    = 1 + CORR_ID_BYTES;

  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned COUNT_W      = 16;
  localparam int unsigned FOFF_W       = 16;
  localparam int unsigned TYPE_W       = 8;
  localparam int unsigned LEN_W        = 32;

  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned APB_ADDR_W   = 3;
  localparam logic [31:0] MAX_LEN_RESET = 32'd65535;

  typedef enum logic [0:0] {
    REG_MAX_DATA_LENGTH = 1'b0
  } reg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_SHORT    = 3'd2,
    ST_OVERSIZE = 3'd3,
    ST_TRUNC    = 3'd4
  } status_e;

  typedef struct packed {
    status_e               status;
    logic [COUNT_W-1:0]    frame_count;
    logic [FOFF_W-1:0]     fail_offset;
    logic [TYPE_W-1:0]     fail_type;
    logic [LEN_W-1:0]      declared_length;
  } verdict_t;

endpackage

[design/rfv_if.sv]
// Byte stream into the validator.
interface rfv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_byte;
  logic       empty_payload;

  modport source (output valid, output payload_byte, output last_byte,
                  output empty_payload, input ready);
  modport sink   (input valid, input payload_byte, input last_byte,
                  input empty_payload, output ready);
endinterface

// Verdict words out of the validator.
interface rfv_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] frame_count;
  logic [15:0] fail_offset;
  logic [7:0]  fail_type;
  logic [31:0] declared_length;

  modport source (output valid, output status, output frame_count,
                  output fail_offset, output fail_type, output declared_length,
                  input ready);
  modport sink   (input valid, input status, input frame_count,
                  input fail_offset, input fail_type, input declared_length,
                  output ready);
endinterface

[design/request_frame_validator_core.sv]
// Output: the verdict for an accepted byte word marked last (or empty) is built
// combinationally and registered in the output register, or in the skid entry.
// Throughput: one byte word per cycle; the two-entry result buffer keeps input
// ready high until both entries hold verdicts that the sink has not taken.
// Reset: rst_ni is asynchronous and active low; it clears the frame walker and
// the result buffer and sets max_data_length to 65535.
`include "assert_macros.svh"

module request_frame_validator_core
  import rfv_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  // Configuration port. Only max_data_length lives at byte address 0.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,

  rfv_in_if.sink                req_i,
  rfv_out_if.source             vrd_o
);

  // ---------------------------------------------------------------------------
  // Configuration register. The register index is the word address; the two
  // byte-select bits below it are ignored.
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0] max_len_q;
  logic             cfg_wr;
  reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[APB_ADDR_W-1]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_wr && cfg_idx == REG_MAX_DATA_LENGTH) begin
      max_len_q <= pwdata;
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MAX_DATA_LENGTH: prdata = max_len_q;
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Frame walker state. These registers are the input side of the single
  // combinational pass: each accepted byte word is folded into them directly.
  // ---------------------------------------------------------------------------
  logic                   in_data_q,   in_data_d;
  logic [HP_W-1:0]        hdr_pos_q,   hdr_pos_d;
  logic [LEN_W-1:0]       len_acc_q,   len_acc_d;
  logic [LEN_W-1:0]       left_q,      left_d;
  status_e                err_q,       err_d;
  logic [COUNT_W-1:0]     frames_q,    frames_d;
  logic [OFFSET_BITS-1:0] offset_q,    offset_d;
  logic [OFFSET_BITS-1:0] fstart_q,    fstart_d;
  logic [TYPE_W-1:0]      ftype_q,     ftype_d;

  logic                   in_fire;
  logic                   has_result;
  verdict_t               verdict;
  logic [HP_W-1:0]        hdr_pos_inc;
  logic [LEN_W-1:0]       left_dec;
  logic [OFFSET_BITS+FOFF_W-1:0] fstart_wide;

  assign in_fire    = req_i.valid && req_i.ready;
  assign has_result = req_i.last_byte || req_i.empty_payload;

  // Count a completed frame, holding at the top of the counter.
  function automatic logic [COUNT_W-1:0] count_frame(logic [COUNT_W-1:0] cnt);
    return (cnt != '1) ? cnt + COUNT_W'(1) : cnt;
  endfunction

  always_comb begin
    in_data_d   = in_data_q;
    hdr_pos_d   = hdr_pos_q;
    len_acc_d   = len_acc_q;
    left_d      = left_q;
    err_d       = err_q;
    frames_d    = frames_q;
    fstart_d    = fstart_q;
    ftype_d     = ftype_q;
    hdr_pos_inc = hdr_pos_q + HP_W'(1);
    left_dec    = (left_q != '0) ? left_q - LEN_W'(1) : left_q;

    // Once an error has latched, the rest of the payload is absorbed.
    if (err_q == ST_OK) begin
      if (!in_data_q) begin
        // Header phase: type byte first, then the correlation id (dropped),
        // then the big-endian data length.
        if (hdr_pos_q == '0) begin
          fstart_d  = offset_q;
          ftype_d   = req_i.payload_byte;
          len_acc_d = '0;
        end else if (hdr_pos_q >= HP_W'(LEN_START)) begin
          len_acc_d = {len_acc_q[LEN_W-9:0], req_i.payload_byte};
        end

        if (hdr_pos_inc >= HP_W'(HDR_BYTES)) begin
          // Header complete. The oversize check comes before anything else.
          hdr_pos_d = '0;
          if (len_acc_d > max_len_q) begin
            err_d = ST_OVERSIZE;
          end else if (len_acc_d == '0) begin
            frames_d = count_frame(frames_q);
          end else begin
            in_data_d = 1'b1;
            left_d    = len_acc_d;
          end
        end else begin
          hdr_pos_d = hdr_pos_inc;
        end
      end else begin
        left_d = left_dec;
        if (left_dec == '0) begin
          in_data_d = 1'b0;
          frames_d  = count_frame(frames_q);
        end
      end
    end

    offset_d = (offset_q != '1) ? offset_q + OFFSET_BITS'(1) : offset_q;
  end

  // The verdict is built from the state after this byte. Only the low bits of
  // a wide offset are reported; a narrow one is zero-extended.
  assign fstart_wide = {{FOFF_W{1'b0}}, fstart_d};

  always_comb begin
    verdict.status          = ST_OK;
    verdict.frame_count     = frames_d;
    verdict.fail_offset     = '0;
    verdict.fail_type       = '0;
    verdict.declared_length = '0;
    if (req_i.empty_payload) begin
      // An empty payload wins over any bytes seen before it.
      verdict.status      = ST_EMPTY;
      verdict.frame_count = '0;
    end else if (err_d != ST_OK) begin
      verdict.status          = err_d;
      verdict.fail_offset     = fstart_wide[FOFF_W-1:0];
      verdict.fail_type       = ftype_d;
      verdict.declared_length = len_acc_d;
    end else if (!in_data_d && hdr_pos_d != '0) begin
      verdict.status      = ST_SHORT;
      verdict.fail_offset = fstart_wide[FOFF_W-1:0];
      verdict.fail_type   = ftype_d;
    end else if (in_data_d) begin
      verdict.status          = ST_TRUNC;
      verdict.fail_offset     = fstart_wide[FOFF_W-1:0];
      verdict.fail_type       = ftype_d;
      verdict.declared_length = len_acc_d;
    end
  end

  // The message state is cleared after every verdict; the register keeps its
  // value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_data_q <= 1'b0;
      hdr_pos_q <= '0;
      len_acc_q <= '0;
      left_q    <= '0;
      err_q     <= ST_OK;
      frames_q  <= '0;
      offset_q  <= '0;
      fstart_q  <= '0;
      ftype_q   <= '0;
    end else if (in_fire) begin
      if (has_result) begin
        in_data_q <= 1'b0;
        hdr_pos_q <= '0;
        len_acc_q <= '0;
        left_q    <= '0;
        err_q     <= ST_OK;
        frames_q  <= '0;
        offset_q  <= '0;
        fstart_q  <= '0;
        ftype_q   <= '0;
      end else begin
        in_data_q <= in_data_d;
        hdr_pos_q <= hdr_pos_d;
        len_acc_q <= len_acc_d;
        left_q    <= left_d;
        err_q     <= err_d;
        frames_q  <= frames_d;
        offset_q  <= offset_d;
        fstart_q  <= fstart_d;
        ftype_q   <= ftype_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result buffer: an output register plus a skid entry. Input stays ready as
  // long as the skid entry is free, so bytes keep flowing while a verdict
  // waits at the output.
  // ---------------------------------------------------------------------------
  verdict_t out_q,  out_d;
  verdict_t skid_q, skid_d;
  logic     out_vld_q,  out_vld_d;
  logic     skid_vld_q, skid_vld_d;
  logic     push;
  logic     out_fire;

  assign push        = in_fire && has_result;
  assign out_fire    = out_vld_q && vrd_o.ready;
  assign req_i.ready = !skid_vld_q;

  always_comb begin
    out_d      = out_q;
    skid_d     = skid_q;
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    if (out_fire || !out_vld_q) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_d     = verdict;
        skid_vld_d = push;
      end else begin
        out_d     = verdict;
        out_vld_d = push;
      end
    end else if (push) begin
      skid_d     = verdict;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign vrd_o.valid           = out_vld_q;
  assign vrd_o.status          = out_q.status;
  assign vrd_o.frame_count     = out_q.frame_count;
  assign vrd_o.fail_offset     = out_q.fail_offset;
  assign vrd_o.fail_type       = out_q.fail_type;
  assign vrd_o.declared_length = out_q.declared_length;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `RFV_ASSERT_NEVER(a_skid_without_out, skid_vld_q && !out_vld_q)
  `RFV_ASSERT(a_data_phase_has_bytes, in_data_q |-> (left_q != '0))
  `RFV_ASSERT(a_hdr_pos_range, hdr_pos_q < HP_W'(HDR_BYTES))
  `RFV_ASSERT(a_error_only_oversize,
    (err_q != ST_OK) |-> (err_q == ST_OVERSIZE && !in_data_q && hdr_pos_q == '0))
  `RFV_ASSERT(a_stalled_push_to_skid,
    (push && out_vld_q && !vrd_o.ready) |=> skid_vld_q)

endmodule

[tb/sv/rfv_verdict_checker.sv]
// Watches both word channels and the register port, keeps its own frame walker
// and compares every verdict word with the oldest one it predicted.
module rfv_verdict_checker
  import rfv_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rfv_in_if                     req_mon,
  rfv_out_if                    vrd_mon,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    mismatches,
  output int                    pending_verdicts
);

  logic [31:0]            len_limit;
  logic                   in_body;
  logic [HP_W-1:0]        hdr_idx;
  logic [31:0]            len_shift;
  logic [31:0]            body_left;
  status_e                first_err;
  logic [COUNT_W-1:0]     frames_seen;
  logic [OFFSET_BITS-1:0] byte_pos;
  logic [OFFSET_BITS-1:0] hdr_start;
  logic [7:0]             hdr_type;
  verdict_t               verdict_q[$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] verdict mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is 0x%0h, predicted 0x%0h", name, got, want));
    end
  endtask

  task automatic clear_walk();
    in_body     = 1'b0;
    hdr_idx     = '0;
    len_shift   = '0;
    body_left   = '0;
    first_err   = ST_OK;
    frames_seen = '0;
    byte_pos    = '0;
    hdr_start   = '0;
    hdr_type    = '0;
  endtask

  task automatic count_frame();
    if (frames_seen != '1) begin
      frames_seen++;
    end
  endtask

  // Advances the frame walker by one payload byte. Once an error is latched
  // the rest of the payload is absorbed.
  task automatic walk_byte(input logic [7:0] b);
    if (first_err != ST_OK) begin
      return;
    end
    if (!in_body) begin
      if (hdr_idx == 0) begin
        hdr_start = byte_pos;
        hdr_type  = b;
        len_shift = '0;
      end else if (hdr_idx >= LEN_START) begin
        len_shift = {len_shift[23:0], b};
      end
      hdr_idx++;
      if (hdr_idx >= HDR_BYTES) begin
        hdr_idx = '0;
        if (len_shift > len_limit) begin
          first_err = ST_OVERSIZE;
        end else if (len_shift == 0) begin
          count_frame();
        end else begin
          in_body   = 1'b1;
          body_left = len_shift;
        end
      end
    end else begin
      if (body_left != 0) begin
        body_left--;
      end
      if (body_left == 0) begin
        in_body = 1'b0;
        count_frame();
      end
    end
  endtask

  task automatic predict_verdict(input logic [7:0] b, input logic last,
                                 input logic empty);
    verdict_t v;
    v = '0;
    if (empty) begin
      v.status = ST_EMPTY;
      verdict_q.push_back(v);
      clear_walk();
      return;
    end
    walk_byte(b);
    if (byte_pos != '1) begin
      byte_pos++;
    end
    if (!last) begin
      return;
    end
    v.frame_count = frames_seen;
    if (first_err != ST_OK) begin
      v.status          = first_err;
      v.fail_offset     = FOFF_W'(hdr_start);
      v.fail_type       = hdr_type;
      v.declared_length = len_shift;
    end else if (!in_body && hdr_idx != 0) begin
      v.status      = ST_SHORT;
      v.fail_offset = FOFF_W'(hdr_start);
      v.fail_type   = hdr_type;
    end else if (in_body) begin
      v.status          = ST_TRUNC;
      v.fail_offset     = FOFF_W'(hdr_start);
      v.fail_type       = hdr_type;
      v.declared_length = len_shift;
    end
    verdict_q.push_back(v);
    clear_walk();
  endtask

  initial begin
    mismatches = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      len_limit = MAX_LEN_RESET;
      clear_walk();
      verdict_q.delete();
      pending_verdicts <= 0;
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr == APB_ADDR_W'(4 * int'(REG_MAX_DATA_LENGTH))) begin
        len_limit = pwdata;
      end
      if (req_mon.valid && req_mon.ready) begin
        predict_verdict(req_mon.payload_byte, req_mon.last_byte, req_mon.empty_payload);
      end
      if (vrd_mon.valid && vrd_mon.ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("verdict word arrived with nothing pending");
        end else begin
          want = verdict_q.pop_front();
          check_field("status", 32'(vrd_mon.status), 32'(want.status));
          check_field("frame_count", 32'(vrd_mon.frame_count), 32'(want.frame_count));
          check_field("fail_offset", 32'(vrd_mon.fail_offset), 32'(want.fail_offset));
          check_field("fail_type", 32'(vrd_mon.fail_type), 32'(want.fail_type));
          check_field("declared_length", vrd_mon.declared_length, want.declared_length);
        end
      end
      pending_verdicts <= verdict_q.size();
    end
  end

endmodule

[tb/sv/request_frame_validator_core_tb.sv]
// Stimulus and verdict for the request frame validator. The checker beside the
// block does all prediction and comparison; this module only makes traffic,
// programs the length limit and decides pass or fail.
module request_frame_validator_core_tb;
  import rfv_pkg::*;

  // Total simulated time allowed before the run is declared hung. A correct
  // run of about 1600 byte words finishes well within it even when every
  // word waits out the longest input gap and every verdict the longest output
  // stall.
  localparam longint unsigned RUN_LIMIT   = 64'd5_000_000;
  // Length of the one long output stall that forces the result buffer full.
  localparam int unsigned     HOLD_CYCLES = 200;

  // Shapes of one random payload. Well-formed frames come first unless the
  // kind is noise or empty; the kind decides how the payload ends.
  typedef enum int {
    MSG_OK,
    MSG_SHORT,
    MSG_TRUNC,
    MSG_OVERSIZE,
    MSG_EMPTY_AFTER,
    MSG_NOISE,
    MSG_EMPTY
  } msg_kind_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  rfv_in_if  req_if();
  rfv_out_if vrd_if();

  int          mismatch_cnt;
  int          verdicts_owed;
  int          words_sent;
  bit          idle_on;
  bit          idle_allowed;
  bit          hold_pending;
  logic [31:0] cur_limit;
  logic [7:0]  msg_q[$];

  request_frame_validator_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_if),
    .vrd_o   (vrd_if)
  );

  rfv_verdict_checker verdict_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_mon          (req_if),
    .vrd_mon          (vrd_if),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .mismatches       (mismatch_cnt),
    .pending_verdicts (verdicts_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or a verdict never arrives.
  initial begin
    #(RUN_LIMIT);
    $display("request_frame_validator_core_tb failed");
    $finish;
  end

  // Verdict sink. Each pass through the loop makes exactly one assignment to
  // ready before it waits on the clock again. A requested hold wins over
  // the random bursts so the block's two-entry buffer fills and it has to
  // drop ready on its input side.
  initial begin
    vrd_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        vrd_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        vrd_if.ready <= 1'b0;
        repeat ($urandom_range(0, 3)) @(posedge clk_i);
      end else begin
        vrd_if.ready <= 1'b1;
      end
    end
  end

  // Offers one byte word and returns at the edge where it is taken. When idling
  // is on, a short gap may come first, which puts bubbles at every point of
  // the frame walk (header, length bytes, data, the last word).
  task automatic send_word(input logic [7:0] b, input logic last, input logic empty);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.payload_byte  <= b;
    req_if.last_byte     <= last;
    req_if.empty_payload <= empty;
    do @(posedge clk_i); while (!req_if.ready);
    words_sent++;
  endtask

  // Sends the staged payload with the last flag on its final byte. An empty
  // staging queue becomes an empty-payload word, since no zero-byte payload
  // can be sent otherwise.
  task automatic send_payload();
    if (msg_q.size() == 0) begin
      send_word(8'($urandom), 1'($urandom), 1'b1);
    end else begin
      for (int i = 0; i < msg_q.size(); i++) begin
        send_word(msg_q[i], i == msg_q.size() - 1, 1'b0);
      end
    end
  endtask

  // Stages one frame header: type byte, correlation id, big-endian length.
  task automatic stage_header(input logic [31:0] len);
    msg_q.push_back(8'($urandom));
    repeat (CORR_ID_BYTES) msg_q.push_back(8'($urandom));
    for (int s = 3; s >= 0; s--) begin
      msg_q.push_back(len[8*s +: 8]);
    end
  endtask

  // Picks a data length that the current limit accepts. Mostly short so that
  // payloads stay small, sometimes zero, and sometimes exactly the limit when
  // the limit is small enough to send.
  function automatic logic [31:0] pick_legal_length();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (cur_limit == 0 || r < 2) begin
      return 32'd0;
    end
    if (r == 7 && cur_limit <= 64) begin
      return cur_limit;
    end
    return $urandom_range(1, (cur_limit < 12) ? cur_limit : 12);
  endfunction

  // Builds and sends one random payload: zero to three random well-formed frames,
  // then an ending chosen by kind (noise and empty drop the frames). Kinds that
  // cannot occur under the current limit fall back to a short header.
  task automatic send_random_payload();
    msg_kind_e   kind;
    int unsigned r;
    logic [31:0] len;
    idle_on = idle_allowed && ($urandom_range(0, 3) != 0);
    msg_q.delete();
    repeat ($urandom_range(0, 3)) begin
      len = pick_legal_length();
      stage_header(len);
      repeat (len) msg_q.push_back(8'($urandom));
    end
    r    = $urandom_range(0, 10);
    kind = (r < 5) ? MSG_OK : msg_kind_e'(r - 4);
    if ((kind == MSG_TRUNC && cur_limit == 0) ||
        (kind == MSG_OVERSIZE && cur_limit == '1)) begin
      kind = MSG_SHORT;
    end
    case (kind)
      MSG_SHORT: begin
        repeat ($urandom_range(1, HDR_BYTES - 1)) msg_q.push_back(8'($urandom));
      end
      MSG_TRUNC: begin
        // Either a small length or any legal one; the frame stops early,
        // possibly right at the end of its header.
        if ($urandom_range(0, 1) == 0) begin
          len = $urandom_range(1, (cur_limit < 40) ? cur_limit : 40);
        end else begin
          len = $urandom_range(1, cur_limit);
        end
        stage_header(len);
        repeat ($urandom_range(0, (len - 1 < 6) ? len - 1 : 6)) begin
          msg_q.push_back(8'($urandom));
        end
      end
      MSG_OVERSIZE: begin
        // Just over the limit or anywhere above it; the trailing bytes must be
        // absorbed whatever they look like.
        if ($urandom_range(0, 1) == 0) begin
          len = cur_limit + 1;
        end else begin
          len = $urandom_range(cur_limit + 1, 32'hFFFF_FFFF);
        end
        stage_header(len);
        repeat ($urandom_range(0, 6)) msg_q.push_back(8'($urandom));
      end
      MSG_NOISE: begin
        msg_q.delete();
        repeat ($urandom_range(1, 24)) msg_q.push_back(8'($urandom));
      end
      MSG_EMPTY: begin
        msg_q.delete();
      end
      default: begin
      end
    endcase
    if (kind == MSG_EMPTY_AFTER) begin
      // Earlier bytes are thrown away once the empty flag shows up.
      foreach (msg_q[i]) send_word(msg_q[i], 1'b0, 1'b0);
      send_word(8'($urandom), 1'($urandom), 1'b1);
    end else begin
      send_payload();
    end
  endtask

  task automatic run_random(input int n);
    int target;
    target = words_sent + n;
    while (words_sent < target) send_random_payload();
  endtask

  // Stops the input and waits until every predicted verdict has been taken,
  // then lets the clock run on in case the block still has work in flight.
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (verdicts_owed != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle until pready is seen.
  task automatic write_length_limit(input logic [31:0] lim);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * int'(REG_MAX_DATA_LENGTH));
    pwdata  <= lim;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_limit = lim;
  endtask

  initial begin
    logic [31:0] lim;
    rst_ni               <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    req_if.valid         <= 1'b0;
    req_if.payload_byte  <= '0;
    req_if.last_byte     <= 1'b0;
    req_if.empty_payload <= 1'b0;
    words_sent   = 0;
    idle_on      = 1'b1;
    idle_allowed = 1'b1;
    hold_pending = 1'b0;
    cur_limit    = MAX_LEN_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, under the reset limit of 65535.
    // A bare empty payload.
    send_word(8'hA5, 1'b0, 1'b1);
    // One zero-length frame: complete as soon as its header is.
    msg_q = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
    send_payload();
    // Short header; the type byte is reported.
    msg_q = '{8'h00, 8'hFF};
    send_payload();
    // Empty flag after bytes already sent: the empty verdict wins.
    send_word(8'h12, 1'b0, 1'b0);
    send_word(8'h34, 1'b0, 1'b0);
    send_word(8'hFF, 1'b1, 1'b1);
    // Largest possible declared length, last byte at the end of the header:
    // the size check comes before any truncation check.
    msg_q = '{8'h7E, 8'h5A, 8'hC3, 8'h3C, 8'hA5, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_payload();
    drain();

    // Random part over several limits, both extremes among them. One phase
    // starts with a long output stall while payloads keep coming, and the
    // final phase runs without idling on either side.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: lim = 32'd0;
        1: lim = 32'hFFFF_FFFF;
        2: lim = $urandom_range(1, 16);
        3: lim = $urandom;
        4: lim = $urandom_range(17, 300);
        default: lim = MAX_LEN_RESET;
      endcase
      idle_allowed = (p != 5);
      if (!idle_allowed) begin
        idle_on = 1'b0;
      end
      write_length_limit(lim);
      if (p == 2) begin
        hold_pending = 1'b1;
      end
      run_random(260);
      drain();
    end

    // Wait out every pending verdict, then let the clock run on for stray words.
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (verdicts_owed != 0);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("request_frame_validator_core_tb passed");
    end else begin
      $display("request_frame_validator_core_tb failed");
    end
    $finish;
  end

endmodule
